// ===== rtl/crc_pkg.sv =====
// ----------------------------------------------------------------------------
// crc_pkg - shared types and constants of the circumcircle unit
// Fixed output widths, pipeline lengths, register map and cell data types.
// ----------------------------------------------------------------------------
package crc_pkg;

   // quotient bits kept by the divider; one more cell flags overflow
   localparam int QUOT_BITS   = 34;
   localparam int DIV_CELLS   = QUOT_BITS + 1;

   // square root: 64-bit working words, two radicand bits per cell
   localparam int SQRT_W      = 64;
   localparam int SQRT_STEPS  = 32;
   localparam logic [SQRT_W-1:0] SQRT_TOP = SQRT_W'(64'h4000_0000_0000_0000);

   // result fields
   localparam int CENTER_W    = 32;
   localparam int RADIUS_W    = 31;
   localparam int RSP_DATA_W  = 96;
   localparam int RSP_USER_W  = 2;
   localparam logic [RADIUS_W-1:0] RADIUS_MAX = '1;
   localparam logic [CENTER_W-1:0] CENTER_MAX = 32'h7FFF_FFFF;
   localparam logic [CENTER_W-1:0] CENTER_MIN = 32'h8000_0000;

   // register map
   localparam int CSR_ADDR_W  = 3;
   localparam logic CSR_THRESHOLD = 1'b0;
   localparam logic [31:0] THRESHOLD_RESET = 32'd1100;

   // data handed from one root cell to the next
   typedef struct packed {
      logic [SQRT_W-1:0] rem;
      logic [SQRT_W-1:0] root;
      logic [SQRT_W-1:0] bitv;
   } crc_sqrt_type;

   // per-request flags and centre that ride beside the root cells
   typedef struct packed {
      logic                reject;
      logic                cen_sat;
      logic                rad_sat;
      logic [CENTER_W-1:0] cen_x;
      logic [CENTER_W-1:0] cen_y;
   } crc_side_type;

endpackage

// ===== rtl/circumcircle_three_points_unit.sv =====
// ----------------------------------------------------------------------------
// circumcircle_three_points_unit - circumcentre and circumradius of 3 points
// Pipeline: 8 front stages, 35 division cells, 3 radius stages, 32 root cells
// and an output register.
// Throughput: one request per cycle; the whole pipeline holds while a result
// waits on the output. Reset clears the pipeline and sets the threshold to 1100.
// ----------------------------------------------------------------------------
module circumcircle_three_points_unit #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // point_a_x, point_a_y, point_b_x, point_b_y, point_c_x, point_c_y
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // center_x, center_y, radius
   output logic [crc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // status, saturated
   output logic [crc_pkg::RSP_USER_W-1:0]     rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [crc_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import crc_pkg::*;

   localparam int W   = COORD_WIDTH;
   localparam int CW  = W + 1;           // point differences
   localparam int PP  = 2*W + 2;         // small products
   localparam int BW  = 2*W + 2;         // squared lengths
   localparam int LO  = W + 1;           // low split of a squared length
   localparam int SPW = 2*W + 3;         // split products
   localparam int PW  = 3*W + 4;         // full numerator products
   localparam int NW  = 3*W + 5;         // numerators
   localparam int DW  = 2*W + 4;         // determinant
   localparam int AW  = 2*W + 3;         // |determinant|
   localparam int RW  = 2*W + QUOT_BITS + 4;
   localparam int CNW = QUOT_BITS + 2;   // centre before clipping
   localparam int LAT = 8 + DIV_CELLS + 3 + SQRT_STEPS + 1;

   logic           en;
   logic [LAT-1:0] vld_ff;
   logic [31:0]    thr_ff;

   // ---------------------------------------------------------------- control
   assign en         = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_tvalid};
      end
   end

   // ------------------------------------------------------------ config port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_THRESHOLD) ? thr_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THRESHOLD_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == CSR_THRESHOLD) begin
         thr_ff <= csr_pwdata;
      end
   end

   // ----------------------------------------------------- stage 1: offsets
   logic signed [W-1:0]  req_ax, req_ay, req_bx, req_by, req_cx, req_cy;
   logic signed [W-1:0]  s1_ax_ff, s1_ay_ff;
   logic signed [CW-1:0] s1_bx_ff, s1_by_ff, s1_cx_ff, s1_cy_ff;

   assign req_ax = req_tdata[0*W +: W];
   assign req_ay = req_tdata[1*W +: W];
   assign req_bx = req_tdata[2*W +: W];
   assign req_by = req_tdata[3*W +: W];
   assign req_cx = req_tdata[4*W +: W];
   assign req_cy = req_tdata[5*W +: W];

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ax_ff <= req_ax;
         s1_ay_ff <= req_ay;
         s1_bx_ff <= CW'(req_bx) - CW'(req_ax);
         s1_by_ff <= CW'(req_by) - CW'(req_ay);
         s1_cx_ff <= CW'(req_cx) - CW'(req_ax);
         s1_cy_ff <= CW'(req_cy) - CW'(req_ay);
      end
   end

   // ---------------------------------------------------- stage 2: products
   logic signed [W-1:0]  s2_ax_ff, s2_ay_ff;
   logic signed [CW-1:0] s2_bx_ff, s2_by_ff, s2_cx_ff, s2_cy_ff;
   logic signed [PP-1:0] s2_bxcy_ff, s2_bycx_ff, s2_bxbx_ff, s2_byby_ff;
   logic signed [PP-1:0] s2_cxcx_ff, s2_cycy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s2_ax_ff   <= s1_ax_ff;
         s2_ay_ff   <= s1_ay_ff;
         s2_bx_ff   <= s1_bx_ff;
         s2_by_ff   <= s1_by_ff;
         s2_cx_ff   <= s1_cx_ff;
         s2_cy_ff   <= s1_cy_ff;
         s2_bxcy_ff <= s1_bx_ff * s1_cy_ff;
         s2_bycx_ff <= s1_by_ff * s1_cx_ff;
         s2_bxbx_ff <= s1_bx_ff * s1_bx_ff;
         s2_byby_ff <= s1_by_ff * s1_by_ff;
         s2_cxcx_ff <= s1_cx_ff * s1_cx_ff;
         s2_cycy_ff <= s1_cy_ff * s1_cy_ff;
      end
   end

   // ---------------------------------- stage 3: determinant, squared lengths
   logic signed [PP:0]   s2_cross;
   logic signed [W-1:0]  s3_ax_ff, s3_ay_ff;
   logic signed [CW-1:0] s3_bx_ff, s3_by_ff, s3_cx_ff, s3_cy_ff;
   logic signed [DW-1:0] s3_d_ff;
   logic [BW-1:0]        s3_b2_ff, s3_c2_ff;

   assign s2_cross = (PP+1)'(s2_bxcy_ff) - (PP+1)'(s2_bycx_ff);

   always_ff @(posedge clock) begin
      if (en) begin
         s3_ax_ff <= s2_ax_ff;
         s3_ay_ff <= s2_ay_ff;
         s3_bx_ff <= s2_bx_ff;
         s3_by_ff <= s2_by_ff;
         s3_cx_ff <= s2_cx_ff;
         s3_cy_ff <= s2_cy_ff;
         s3_d_ff  <= {s2_cross, 1'b0};
         s3_b2_ff <= $unsigned(s2_bxbx_ff) + $unsigned(s2_byby_ff);
         s3_c2_ff <= $unsigned(s2_cxcx_ff) + $unsigned(s2_cycy_ff);
      end
   end

   // ------------------------ stage 4: collinear test, split numerator products
   logic [DW-1:0]         s3_dabs;
   logic signed [LO:0]    s3_b2l, s3_b2h, s3_c2l, s3_c2h;
   logic signed [W-1:0]   s4_ax_ff, s4_ay_ff;
   logic [AW-1:0]         s4_absd_ff;
   logic                  s4_sd_ff, s4_reject_ff;
   logic signed [SPW-1:0] s4_cyb2l_ff, s4_cyb2h_ff, s4_byc2l_ff, s4_byc2h_ff;
   logic signed [SPW-1:0] s4_bxc2l_ff, s4_bxc2h_ff, s4_cxb2l_ff, s4_cxb2h_ff;

   assign s3_dabs = s3_d_ff[DW-1] ? $unsigned(-s3_d_ff) : $unsigned(s3_d_ff);
   assign s3_b2l  = $signed({1'b0, s3_b2_ff[LO-1:0]});
   assign s3_b2h  = $signed({1'b0, s3_b2_ff[BW-1:LO]});
   assign s3_c2l  = $signed({1'b0, s3_c2_ff[LO-1:0]});
   assign s3_c2h  = $signed({1'b0, s3_c2_ff[BW-1:LO]});

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ax_ff     <= s3_ax_ff;
         s4_ay_ff     <= s3_ay_ff;
         s4_absd_ff   <= s3_dabs[AW-1:0];
         s4_sd_ff     <= s3_d_ff[DW-1];
         s4_reject_ff <= (AW+32)'(s3_dabs[AW-1:0]) <= (AW+32)'(thr_ff);
         s4_cyb2l_ff  <= s3_cy_ff * s3_b2l;
         s4_cyb2h_ff  <= s3_cy_ff * s3_b2h;
         s4_byc2l_ff  <= s3_by_ff * s3_c2l;
         s4_byc2h_ff  <= s3_by_ff * s3_c2h;
         s4_bxc2l_ff  <= s3_bx_ff * s3_c2l;
         s4_bxc2h_ff  <= s3_bx_ff * s3_c2h;
         s4_cxb2l_ff  <= s3_cx_ff * s3_b2l;
         s4_cxb2h_ff  <= s3_cx_ff * s3_b2h;
      end
   end

   // ------------------------------------------ stage 5: join partial products
   logic signed [W-1:0]  s5_ax_ff, s5_ay_ff;
   logic [AW-1:0]        s5_absd_ff;
   logic                 s5_sd_ff, s5_reject_ff;
   logic signed [PW-1:0] s5_cyb2_ff, s5_byc2_ff, s5_bxc2_ff, s5_cxb2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s5_ax_ff     <= s4_ax_ff;
         s5_ay_ff     <= s4_ay_ff;
         s5_absd_ff   <= s4_absd_ff;
         s5_sd_ff     <= s4_sd_ff;
         s5_reject_ff <= s4_reject_ff;
         s5_cyb2_ff   <= (PW'(s4_cyb2h_ff) <<< LO) + PW'(s4_cyb2l_ff);
         s5_byc2_ff   <= (PW'(s4_byc2h_ff) <<< LO) + PW'(s4_byc2l_ff);
         s5_bxc2_ff   <= (PW'(s4_bxc2h_ff) <<< LO) + PW'(s4_bxc2l_ff);
         s5_cxb2_ff   <= (PW'(s4_cxb2h_ff) <<< LO) + PW'(s4_cxb2l_ff);
      end
   end

   // ------------------------------------------------- stage 6: numerators
   logic signed [W-1:0]  s6_ax_ff, s6_ay_ff;
   logic [AW-1:0]        s6_absd_ff;
   logic                 s6_sd_ff, s6_reject_ff;
   logic signed [NW-1:0] s6_nx_ff, s6_ny_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s6_ax_ff     <= s5_ax_ff;
         s6_ay_ff     <= s5_ay_ff;
         s6_absd_ff   <= s5_absd_ff;
         s6_sd_ff     <= s5_sd_ff;
         s6_reject_ff <= s5_reject_ff;
         s6_nx_ff     <= NW'(s5_cyb2_ff) - NW'(s5_byc2_ff);
         s6_ny_ff     <= NW'(s5_bxc2_ff) - NW'(s5_cxb2_ff);
      end
   end

   // ------------------------------------ stage 7: magnitudes and result signs
   logic signed [W-1:0] s7_ax_ff, s7_ay_ff;
   logic [AW-1:0]       s7_absd_ff;
   logic                s7_reject_ff, s7_negx_ff, s7_negy_ff;
   logic [NW-1:0]       s7_nxa_ff, s7_nya_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s7_ax_ff     <= s6_ax_ff;
         s7_ay_ff     <= s6_ay_ff;
         s7_absd_ff   <= s6_absd_ff;
         s7_reject_ff <= s6_reject_ff;
         s7_negx_ff   <= s6_nx_ff[NW-1] ^ s6_sd_ff;
         s7_negy_ff   <= s6_ny_ff[NW-1] ^ s6_sd_ff;
         s7_nxa_ff    <= s6_nx_ff[NW-1] ? $unsigned(-s6_nx_ff) : $unsigned(s6_nx_ff);
         s7_nya_ff    <= s6_ny_ff[NW-1] ? $unsigned(-s6_ny_ff) : $unsigned(s6_ny_ff);
      end
   end

   // ---------------- stage 8: rounded dividend 2|n|+|d|, divisor 2|d| shifted
   logic signed [W-1:0] s8_ax_ff, s8_ay_ff;
   logic                s8_reject_ff, s8_negx_ff, s8_negy_ff;
   logic [RW-1:0]       s8_remx_ff, s8_remy_ff, s8_dsh_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s8_ax_ff     <= s7_ax_ff;
         s8_ay_ff     <= s7_ay_ff;
         s8_reject_ff <= s7_reject_ff;
         s8_negx_ff   <= s7_negx_ff;
         s8_negy_ff   <= s7_negy_ff;
         s8_remx_ff   <= RW'({s7_nxa_ff, 1'b0}) + RW'(s7_absd_ff);
         s8_remy_ff   <= RW'({s7_nya_ff, 1'b0}) + RW'(s7_absd_ff);
         s8_dsh_ff    <= RW'(s7_absd_ff) << (QUOT_BITS + 1);
      end
   end

   // ------------------------------------------------------- division cells
   logic [RW-1:0]        drx [DIV_CELLS+1];
   logic [RW-1:0]        dry [DIV_CELLS+1];
   logic [RW-1:0]        dds [DIV_CELLS+1];
   logic [DIV_CELLS-1:0] dqx [DIV_CELLS+1];
   logic [DIV_CELLS-1:0] dqy [DIV_CELLS+1];
   logic signed [W-1:0]  dax_ff [DIV_CELLS];
   logic signed [W-1:0]  day_ff [DIV_CELLS];
   logic [DIV_CELLS-1:0] drej_ff, dnegx_ff, dnegy_ff;

   assign drx[0] = s8_remx_ff;
   assign dry[0] = s8_remy_ff;
   assign dds[0] = s8_dsh_ff;
   assign dqx[0] = '0;
   assign dqy[0] = '0;

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      crc_div_cell #(
         .RW (RW),
         .QW (DIV_CELLS)
      ) u_cell (
         .clock      (clock),
         .en         (en),
         .prev_rem_x (drx[k]),
         .prev_rem_y (dry[k]),
         .prev_dsh   (dds[k]),
         .prev_quo_x (dqx[k]),
         .prev_quo_y (dqy[k]),
         .next_rem_x (drx[k+1]),
         .next_rem_y (dry[k+1]),
         .next_dsh   (dds[k+1]),
         .next_quo_x (dqx[k+1]),
         .next_quo_y (dqy[k+1])
      );
   end

   // carry the point a and flags beside the division cells
   always_ff @(posedge clock) begin
      if (en) begin
         dax_ff[0] <= s8_ax_ff;
         day_ff[0] <= s8_ay_ff;
         for (int k = 1; k < DIV_CELLS; k++) begin
            dax_ff[k] <= dax_ff[k-1];
            day_ff[k] <= day_ff[k-1];
         end
         drej_ff  <= {drej_ff[DIV_CELLS-2:0], s8_reject_ff};
         dnegx_ff <= {dnegx_ff[DIV_CELLS-2:0], s8_negx_ff};
         dnegy_ff <= {dnegy_ff[DIV_CELLS-2:0], s8_negy_ff};
      end
   end

   // ------------------------------ radius stage 1: centre, clip, magnitudes
   function automatic logic [CENTER_W:0] clip_center(input logic signed [CNW-1:0] v);
      logic [CNW-CENTER_W:0] top;
      top = v[CNW-1:CENTER_W-1];
      if (top == '0 || top == '1) begin
         return {1'b0, v[CENTER_W-1:0]};
      end else if (v[CNW-1]) begin
         return {1'b1, CENTER_MIN};
      end else begin
         return {1'b1, CENTER_MAX};
      end
   endfunction

   logic [QUOT_BITS-1:0]      qmx, qmy;
   logic                      ovfx, ovfy;
   logic signed [QUOT_BITS:0] ux, uy;
   logic [CENTER_W:0]         clx, cly;
   logic                      negx, negy;
   crc_side_type              p1_side_in, p1_side_ff;
   logic [RADIUS_W-1:0]       p1_mx_ff, p1_my_ff;

   always_comb begin
      qmx  = dqx[DIV_CELLS][QUOT_BITS-1:0];
      qmy  = dqy[DIV_CELLS][QUOT_BITS-1:0];
      ovfx = dqx[DIV_CELLS][QUOT_BITS];
      ovfy = dqy[DIV_CELLS][QUOT_BITS];
      negx = dnegx_ff[DIV_CELLS-1];
      negy = dnegy_ff[DIV_CELLS-1];
      ux   = negx ? -$signed({1'b0, qmx}) : $signed({1'b0, qmx});
      uy   = negy ? -$signed({1'b0, qmy}) : $signed({1'b0, qmy});
      clx  = clip_center(CNW'(dax_ff[DIV_CELLS-1]) + CNW'(ux));
      cly  = clip_center(CNW'(day_ff[DIV_CELLS-1]) + CNW'(uy));
      // a quotient past the kept bits lands out of range on its own side
      if (ovfx) begin
         clx = {1'b1, negx ? CENTER_MIN : CENTER_MAX};
      end
      if (ovfy) begin
         cly = {1'b1, negy ? CENTER_MIN : CENTER_MAX};
      end
      p1_side_in.reject  = drej_ff[DIV_CELLS-1];
      p1_side_in.cen_sat = clx[CENTER_W] | cly[CENTER_W];
      p1_side_in.rad_sat = ovfx | ovfy | (|qmx[QUOT_BITS-1:RADIUS_W])
                           | (|qmy[QUOT_BITS-1:RADIUS_W]);
      p1_side_in.cen_x   = clx[CENTER_W-1:0];
      p1_side_in.cen_y   = cly[CENTER_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_side_ff <= p1_side_in;
         p1_mx_ff   <= qmx[RADIUS_W-1:0];
         p1_my_ff   <= qmy[RADIUS_W-1:0];
      end
   end

   // -------------------------------------- radius stages 2 and 3: squares, sum
   crc_side_type          p2_side_ff, p3_side_ff;
   logic [2*RADIUS_W-1:0] p2_sqx_ff, p2_sqy_ff;
   crc_sqrt_type          p3_sq_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p2_side_ff    <= p1_side_ff;
         p2_sqx_ff     <= p1_mx_ff * p1_mx_ff;
         p2_sqy_ff     <= p1_my_ff * p1_my_ff;
         p3_side_ff    <= p2_side_ff;
         p3_sq_ff.rem  <= SQRT_W'(p2_sqx_ff) + SQRT_W'(p2_sqy_ff);
         p3_sq_ff.root <= '0;
         p3_sq_ff.bitv <= SQRT_TOP;
      end
   end

   // ----------------------------------------------------------- root cells
   crc_sqrt_type sq_chain [SQRT_STEPS+1];
   crc_side_type sside_ff [SQRT_STEPS];

   assign sq_chain[0] = p3_sq_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      crc_sqrt_cell u_cell (
         .clock (clock),
         .en    (en),
         .prev  (sq_chain[k]),
         .next  (sq_chain[k+1])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sside_ff[0] <= p3_side_ff;
         for (int k = 1; k < SQRT_STEPS; k++) begin
            sside_ff[k] <= sside_ff[k-1];
         end
      end
   end

   // ------------------------------------------- output: round, clip, present
   crc_side_type              o_side;
   crc_sqrt_type              o_sq;
   logic [SQRT_W-1:0]         o_rnd;
   logic                      o_rclip;
   logic [RADIUS_W-1:0]       o_rad;
   logic [RSP_DATA_W-1:0]     rsp_tdata_in, rsp_tdata_ff;
   logic [RSP_USER_W-1:0]     rsp_tuser_in, rsp_tuser_ff;

   always_comb begin
      o_side  = sside_ff[SQRT_STEPS-1];
      o_sq    = sq_chain[SQRT_STEPS];
      o_rnd   = o_sq.root + SQRT_W'(o_sq.rem > o_sq.root);
      o_rclip = o_side.rad_sat || (o_rnd > SQRT_W'(RADIUS_MAX));
      o_rad   = o_rclip ? RADIUS_MAX : o_rnd[RADIUS_W-1:0];
      if (o_side.reject) begin
         rsp_tdata_in = '0;
         rsp_tuser_in = 2'b01;
      end else begin
         rsp_tdata_in = {1'b0, o_rad, o_side.cen_y, o_side.cen_x};
         rsp_tuser_in = {o_side.cen_sat | o_rclip, 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_tdata_ff <= rsp_tdata_in;
         rsp_tuser_ff <= rsp_tuser_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;
endmodule

// ===== rtl/crc_div_cell.sv =====
// ----------------------------------------------------------------------------
// crc_div_cell - one restoring division step for both centre offsets
// Compares each remainder with the shifted divisor, subtracts on success,
// appends a quotient bit and hands the halved divisor to the next cell.
// ----------------------------------------------------------------------------
module crc_div_cell #(
   parameter int RW = 86,
   parameter int QW = 35
) (
   input  logic          clock,
   input  logic          en,
   input  logic [RW-1:0] prev_rem_x,
   input  logic [RW-1:0] prev_rem_y,
   input  logic [RW-1:0] prev_dsh,
   input  logic [QW-1:0] prev_quo_x,
   input  logic [QW-1:0] prev_quo_y,
   output logic [RW-1:0] next_rem_x,
   output logic [RW-1:0] next_rem_y,
   output logic [RW-1:0] next_dsh,
   output logic [QW-1:0] next_quo_x,
   output logic [QW-1:0] next_quo_y
);
   logic          ge_x, ge_y;
   logic [RW-1:0] rem_x_in, rem_y_in, rem_x_ff, rem_y_ff, dsh_in, dsh_ff;
   logic [QW-1:0] quo_x_in, quo_y_in, quo_x_ff, quo_y_ff;

   // trial subtract
   always_comb begin
      ge_x     = prev_rem_x >= prev_dsh;
      ge_y     = prev_rem_y >= prev_dsh;
      rem_x_in = ge_x ? prev_rem_x - prev_dsh : prev_rem_x;
      rem_y_in = ge_y ? prev_rem_y - prev_dsh : prev_rem_y;
      dsh_in   = prev_dsh >> 1;
      quo_x_in = {prev_quo_x[QW-2:0], ge_x};
      quo_y_in = {prev_quo_y[QW-2:0], ge_y};
   end

   // advance with the pipeline
   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         dsh_ff   <= dsh_in;
         quo_x_ff <= quo_x_in;
         quo_y_ff <= quo_y_in;
      end
   end

   assign next_rem_x = rem_x_ff;
   assign next_rem_y = rem_y_ff;
   assign next_dsh   = dsh_ff;
   assign next_quo_x = quo_x_ff;
   assign next_quo_y = quo_y_ff;
endmodule

// ===== rtl/crc_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// crc_sqrt_cell - one digit step of the integer square root
// Settles one root bit per cell from two radicand bits.
// ----------------------------------------------------------------------------
module crc_sqrt_cell (
   input  logic                  clock,
   input  logic                  en,
   input  crc_pkg::crc_sqrt_type prev,
   output crc_pkg::crc_sqrt_type next
);
   import crc_pkg::*;

   logic              ge;
   logic [SQRT_W-1:0] trial;
   crc_sqrt_type      step_in, step_ff;

   // try the next root bit
   always_comb begin
      trial        = prev.root + prev.bitv;
      ge           = prev.rem >= trial;
      step_in.rem  = ge ? prev.rem - trial : prev.rem;
      step_in.root = ge ? (prev.root >> 1) + prev.bitv : prev.root >> 1;
      step_in.bitv = prev.bitv >> 2;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign next = step_ff;
endmodule

// ===== rtl/crc_checker.sv =====
// ----------------------------------------------------------------------------
// crc_checker - port-level checks of the circumcircle unit
// Watches the result channel and the stall behaviour seen on the ports.
// ----------------------------------------------------------------------------
module crc_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [crc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [crc_pkg::RSP_USER_W-1:0] rsp_tuser
);
   // hold a stalled result
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // collinear result carries zero payload and no saturation
   a_reject_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == '0 && !rsp_tuser[1])
      else $error("rejected result not cleared");

   // reset empties the pipeline
   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // a held result stops new requests
   a_stall_input : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline held");
endmodule

bind circumcircle_three_points_unit crc_checker u_crc_checker (.*);

// ===== sim/tb_circumcircle_three_points_unit.sv =====
// ----------------------------------------------------------------------------
// tb_circumcircle_three_points_unit - self-checking bench of the circumcircle unit
// Drives point triples through the request stream with random gaps and stalls,
// predicts centre, radius and flags at full precision, and compares each result
// in order. The collinearity threshold is reprogrammed between phases.
// ----------------------------------------------------------------------------
module tb_circumcircle_three_points_unit;
   import crc_pkg::*;

   localparam int CW        = 24;
   localparam int REQ_W     = ((6*CW+7)/8)*8;
   localparam int IDLE_MAX  = 3000;
   localparam int DRAIN_GAP = 100;

   typedef logic signed [CW-1:0] coord_type;
   typedef struct {
      coord_type ax, ay, bx, by, cx, cy;
   } tri_type;
   typedef struct {
      logic                 status;
      logic signed [31:0]   cen_x;
      logic signed [31:0]   cen_y;
      logic [RADIUS_W-1:0]  radius;
      logic                 sat;
   } circle_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   tri_type    tri_pending[$];
   circle_type circle_expected[$];
   logic [31:0] threshold_model = THRESHOLD_RESET;
   int n_results = 0, n_mismatch = 0, n_reject = 0, n_sat = 0;
   int idle_cycles = 0;
   bit csr_busy = 1'b0;

   circumcircle_three_points_unit #(.COORD_WIDTH(CW)) i_dut (.*);

   always #10 clock = ~clock;

   // floor square root of a 64-bit value
   function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
      logic [63:0] r, b, x;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      x = s;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // quotient rounded to nearest, ties away from zero
   function automatic logic signed [127:0] round_div(input logic signed [127:0] n,
                                                     input logic signed [127:0] d);
      logic [127:0] an, ad, q;
      an = n[127] ? -n : n;
      ad = d[127] ? -d : d;
      q = (2*an + ad) / (2*ad);
      return (n[127] != d[127]) ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic signed [31:0] clip_centre(input logic signed [127:0] v,
                                                      inout logic sat);
      if (v > 128'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -128'sd2147483648) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // circumcentre and radius of one triple
   function automatic circle_type circumcircle(input tri_type t);
      circle_type o;
      logic signed [127:0] ax, ay, bx, by, cx, cy, d, ad, b2, c2, ux, uy, mx, my;
      logic [63:0] s, r;
      logic sat;
      ax = t.ax; ay = t.ay;
      bx = 128'(signed'(t.bx)) - ax; by = 128'(signed'(t.by)) - ay;
      cx = 128'(signed'(t.cx)) - ax; cy = 128'(signed'(t.cy)) - ay;
      d = 2 * (bx*cy - by*cx);
      ad = d[127] ? -d : d;
      o = '{1'b1, 32'sd0, 32'sd0, '0, 1'b0};
      if (ad <= {96'd0, threshold_model}) return o;
      sat = 1'b0;
      b2 = bx*bx + by*by;
      c2 = cx*cx + cy*cy;
      ux = round_div(cy*b2 - by*c2, d);
      uy = round_div(bx*c2 - cx*b2, d);
      o.status = 1'b0;
      o.cen_x = clip_centre(ax + ux, sat);
      o.cen_y = clip_centre(ay + uy, sat);
      mx = ux[127] ? -ux : ux;
      my = uy[127] ? -uy : uy;
      if (mx > 128'sd2147483647 || my > 128'sd2147483647) begin
         o.radius = RADIUS_MAX;
         sat = 1'b1;
      end else begin
         s = mx[63:0]*mx[63:0] + my[63:0]*my[63:0];
         r = floor_sqrt(s);
         if (s - r*r > r) r = r + 1;
         if (r > 64'h7FFF_FFFF) begin
            r = 64'h7FFF_FFFF;
            sat = 1'b1;
         end
         o.radius = r[30:0];
      end
      o.sat = sat;
      return o;
   endfunction

   function automatic coord_type rand_coord();
      return coord_type'($urandom);
   endfunction

   // random triple of one of several shapes
   function automatic tri_type random_tri();
      tri_type t;
      int dx, dy, k;
      coord_type edges[5];
      edges = '{24'sh800000, 24'sh7FFFFF, 24'sd0, -24'sd1, 24'sd1};
      case ($urandom_range(0, 9))
         0, 1, 2: begin
            t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord()};
         end
         3, 4, 5: begin
            // small triangle somewhere in the plane
            t.ax = rand_coord(); t.ay = rand_coord();
            t.bx = t.ax + coord_type'($urandom_range(0, 8191) - 4096);
            t.by = t.ay + coord_type'($urandom_range(0, 8191) - 4096);
            t.cx = t.ax + coord_type'($urandom_range(0, 8191) - 4096);
            t.cy = t.ay + coord_type'($urandom_range(0, 8191) - 4096);
         end
         6, 7: begin
            // close to a line: far centre, threshold decides
            dx = $urandom_range(0, 131071) - 65536;
            dy = $urandom_range(0, 131071) - 65536;
            k = $urandom_range(0, 16) - 8;
            t.ax = coord_type'($urandom_range(0, 4194303) - 2097152);
            t.ay = coord_type'($urandom_range(0, 4194303) - 2097152);
            t.bx = t.ax + coord_type'(dx); t.by = t.ay + coord_type'(dy);
            t.cx = t.ax + coord_type'(k*dx + $urandom_range(0, 6) - 3);
            t.cy = t.ay + coord_type'(k*dy + $urandom_range(0, 6) - 3);
         end
         8: begin
            t = '{edges[$urandom_range(0,4)], edges[$urandom_range(0,4)],
                  edges[$urandom_range(0,4)], edges[$urandom_range(0,4)],
                  edges[$urandom_range(0,4)], edges[$urandom_range(0,4)]};
         end
         default: begin
            // two coincident points
            t = '{rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord()};
            t.cx = t.bx; t.cy = t.by;
         end
      endcase
      return t;
   endfunction

   // request driver
   int  req_gap = 0;
   bit  req_burst = 1'b0;
   tri_type req_cur;
   always @(posedge clock) begin
      logic v;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         v = req_tvalid;
         if (req_tvalid && req_tready) begin
            circle_expected = {circle_expected, circumcircle(req_cur)};
            v = 1'b0;
            if ($urandom_range(0, 99) == 0) req_burst = !req_burst;
            req_gap = req_burst ? 0 : $urandom_range(0, 8);
         end
         if (!v) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (tri_pending.size() > 0) begin
               req_cur = tri_pending.pop_front();
               req_tdata <= {req_cur.cy, req_cur.cx, req_cur.by, req_cur.bx,
                             req_cur.ay, req_cur.ax};
               v = 1'b1;
            end
         end
         req_tvalid <= v;
      end
   end

   // result monitor with random stalls and one long hold-off
   int  rsp_stall = 0;
   int  rsp_hold = 0;
   bit  rsp_held = 1'b0;
   bit  rsp_burst = 1'b0;
   always @(posedge clock) begin
      circle_type e;
      circle_type got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.cen_x  = rsp_tdata[31:0];
            got.cen_y  = rsp_tdata[63:32];
            got.radius = rsp_tdata[94:64];
            got.status = rsp_tuser[0];
            got.sat    = rsp_tuser[1];
            n_results++;
            if (circle_expected.size() == 0) begin
               n_mismatch++;
               if (n_mismatch <= 10)
                  $display("unexpected result %h/%b", rsp_tdata, rsp_tuser);
            end else begin
               e = circle_expected.pop_front();
               if (e.status) n_reject++;
               if (e.sat) n_sat++;
               if (got.status !== e.status || got.cen_x !== e.cen_x ||
                   got.cen_y !== e.cen_y || got.radius !== e.radius ||
                   got.sat !== e.sat || rsp_tdata[95] !== 1'b0) begin
                  n_mismatch++;
                  if (n_mismatch <= 10)
                     $display({"mismatch #%0d: exp st=%b cx=%h cy=%h r=%h sat=%b,",
                               " got st=%b cx=%h cy=%h r=%h sat=%b"},
                              n_results, e.status, e.cen_x, e.cen_y, e.radius, e.sat,
                              got.status, got.cen_x, got.cen_y, got.radius, got.sat);
               end
            end
            if ($urandom_range(0, 99) == 0) rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 8);
            if (n_results == 300 && !rsp_held) begin
               rsp_hold = 400;
               rsp_held = 1'b1;
            end
         end else if (rsp_hold > 0) begin
            rsp_hold--;
         end else if (rsp_stall > 0) begin
            rsp_stall--;
         end
         rsp_tready <= (rsp_hold == 0 && rsp_stall == 0);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_busy || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
         $display("watchdog: no transfer for %0d cycles", idle_cycles);
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_threshold(input logic [31:0] value);
      csr_busy = 1'b1;
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_penable <= 1'b0;
      csr_paddr <= CSR_ADDR_W'(CSR_THRESHOLD) << 2; csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      threshold_model = value;
      // read back
      @(posedge clock);
      csr_psel <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (csr_prdata !== value) begin
         n_mismatch++;
         if (n_mismatch <= 10) $display("threshold read %h, wrote %h", csr_prdata, value);
      end
      csr_psel <= 1'b0; csr_penable <= 1'b0;
      csr_busy = 1'b0;
   endtask

   // hold until every queued request has produced its result
   task automatic drain();
      while (tri_pending.size() > 0 || req_tvalid || circle_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_GAP) @(posedge clock);
   endtask

   task automatic push_tri(input int ax, ay, bx, by, cx, cy);
      tri_type t;
      t = '{coord_type'(ax), coord_type'(ay), coord_type'(bx), coord_type'(by),
            coord_type'(cx), coord_type'(cy)};
      tri_pending = {tri_pending, t};
   endtask

   task automatic push_random(input int n);
      repeat (n) tri_pending = {tri_pending, random_tri()};
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: degenerate, extremes, threshold boundary, clipping
      push_tri(0, 0, 0, 0, 0, 0);
      push_tri(8388607, 8388607, 8388607, 8388607, 8388607, 8388607);
      push_tri(-8388608, -8388608, 8388607, -8388608, -8388608, 8388607);
      push_tri(8388607, 8388607, -8388608, 8388607, 8388607, -8388608);
      push_tri(0, 0, 1 << 20, 0, 0, 1 << 20);
      push_tri(-8388608, 0, 8388607, 0, 0, 8388607);
      push_tri(0, 0, 1 << 20, 1 << 20, 2 << 20, 2 << 20);
      push_tri(0, 0, 1, 0, 0, 550);
      push_tri(0, 0, 1, 0, 0, 551);
      push_tri(0, 0, 1, 0, 0, -551);
      push_tri(-8388608, -8388608, 8388607, 8388607, 0, 1);
      push_tri(8388607, -8388608, -8388608, 8388607, 1, 0);
      push_tri(0, 0, 1, 0, 0, 1 << 22);
      push_tri(-1, -1, 1, 1, 1, -1);
      push_tri(100, 200, 100, 200, 5000, -3000);
      push_tri(8388607, 0, -8388608, 0, 0, -8388608);
      push_random(250);
      drain();

      write_threshold(32'd0);
      push_tri(0, 0, 1, 0, 0, 1);
      push_tri(0, 0, 1, 0, 0, -1);
      push_random(200);
      drain();

      write_threshold(32'hFFFF_FFFF);
      push_tri(0, 0, 1 << 16, 0, 0, 1 << 15);
      push_random(150);
      drain();

      write_threshold($urandom);
      push_random(120);
      drain();

      write_threshold(32'd1100);
      push_random(130);
      drain();

      $display("checked %0d circles: %0d collinear, %0d clipped, %0d mismatches",
               n_results, n_reject, n_sat, n_mismatch);
      $display("thresholds 0, 1100, all ones and random; long output hold-off applied");
      if (n_mismatch == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== circumcircle_three_points_unit.f =====
rtl/crc_pkg.sv
rtl/crc_div_cell.sv
rtl/crc_sqrt_cell.sv
rtl/circumcircle_three_points_unit.sv
rtl/crc_checker.sv
sim/tb_circumcircle_three_points_unit.sv
